// ----- rtl/core/adsr_pkg.sv -----
package adsr_pkg;

    localparam int FRAC_BITS  = 23;
    localparam int LEVEL_W    = FRAC_BITS + 1;
    localparam int SAMPLE_W   = 24;
    localparam int CURVE_W    = 16;
    localparam int ACT_W      = 2;
    localparam int STAGE_W    = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int MUL_W      = 32;
    localparam int PROD_W     = 2 * MUL_W;

    localparam logic [LEVEL_W-1:0] ONE_LVL = LEVEL_W'(1) << FRAC_BITS;

    // action codes
    localparam logic [ACT_W-1:0] ACT_TICK = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ON   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_OFF  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_RST  = 2'd3;

    // envelope stages
    localparam logic [STAGE_W-1:0] STG_IDLE = 3'd0;
    localparam logic [STAGE_W-1:0] STG_ATK  = 3'd1;
    localparam logic [STAGE_W-1:0] STG_DEC  = 3'd2;
    localparam logic [STAGE_W-1:0] STG_SUS  = 3'd3;
    localparam logic [STAGE_W-1:0] STG_REL  = 3'd4;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_ATTACK  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DECAY   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RELEASE = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SUSTAIN = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CURVE   = 3'd4;

    typedef struct packed {
        logic [LEVEL_W-1:0]        attack_step;
        logic [LEVEL_W-1:0]        decay_step;
        logic [LEVEL_W-1:0]        rel_step;
        logic [LEVEL_W-1:0]        sustain_level;
        logic signed [CURVE_W-1:0] curve_amount;
    } t_cfg;

    typedef struct packed {
        logic [ACT_W-1:0]           action;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_req;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [LEVEL_W-1:0]  env;
        logic [STAGE_W-1:0]  stage;
        logic                last;
    } t_res;

    // 2^-(2^-(i+1)) in q1.30
    function automatic logic [29:0] exp_tab(input logic [3:0] i);
        logic [29:0] v;
        case (i)
            4'd0:  v = 30'd759250125;
            4'd1:  v = 30'd902905651;
            4'd2:  v = 30'd984625594;
            4'd3:  v = 30'd1028218693;
            4'd4:  v = 30'd1050733751;
            4'd5:  v = 30'd1062175491;
            4'd6:  v = 30'd1067942999;
            4'd7:  v = 30'd1070838486;
            4'd8:  v = 30'd1072289173;
            4'd9:  v = 30'd1073015252;
            4'd10: v = 30'd1073378477;
            4'd11: v = 30'd1073560135;
            4'd12: v = 30'd1073650976;
            4'd13: v = 30'd1073696399;
            4'd14: v = 30'd1073719111;
            default: v = 30'd1073730468;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/adsr_mul.sv -----
module adsr_mul (
    input  logic                                  i_clk,
    input  logic signed [adsr_pkg::MUL_W-1:0]     i_a,
    input  logic signed [adsr_pkg::MUL_W-1:0]     i_b,
    output logic signed [adsr_pkg::PROD_W-1:0]    o_p
);
    import adsr_pkg::*;

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ----- rtl/core/adsr_cfg.sv -----
module adsr_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_we,
    input  logic [adsr_pkg::CFG_ADDR_W-1:0]   i_addr,
    input  logic [adsr_pkg::LEVEL_W-1:0]      i_wdata,
    output adsr_pkg::t_cfg                    o_cfg
);
    import adsr_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_step   <= ONE_LVL;
            r_cfg.decay_step    <= ONE_LVL;
            r_cfg.rel_step      <= ONE_LVL;
            r_cfg.sustain_level <= ONE_LVL;
            r_cfg.curve_amount  <= '0;
        end else if (i_we) begin
            unique case (i_addr)
                REG_ATTACK:  r_cfg.attack_step   <= i_wdata;
                REG_DECAY:   r_cfg.decay_step    <= i_wdata;
                REG_RELEASE: r_cfg.rel_step      <= i_wdata;
                REG_SUSTAIN: r_cfg.sustain_level <= i_wdata;
                REG_CURVE:   r_cfg.curve_amount  <= i_wdata[CURVE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/adsr_core.sv -----
module adsr_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  adsr_pkg::t_cfg    i_cfg,
    input  logic              i_req_valid,
    input  adsr_pkg::t_req    i_req,
    output logic              o_idle,
    output logic              o_res_valid,
    input  logic              i_res_take,
    output adsr_pkg::t_res    o_res
);
    import adsr_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_PREP = 4'd1;
    localparam logic [3:0] ST_NORM = 4'd2;
    localparam logic [3:0] ST_SQ   = 4'd3;
    localparam logic [3:0] ST_SQW  = 4'd4;
    localparam logic [3:0] ST_MAG  = 4'd5;
    localparam logic [3:0] ST_MAGW = 4'd6;
    localparam logic [3:0] ST_EXP  = 4'd7;
    localparam logic [3:0] ST_EXPW = 4'd8;
    localparam logic [3:0] ST_SHF  = 4'd9;
    localparam logic [3:0] ST_POST = 4'd10;
    localparam logic [3:0] ST_SMP  = 4'd11;
    localparam logic [3:0] ST_SMPW = 4'd12;
    localparam logic [3:0] ST_DONE = 4'd13;

    localparam logic signed [CURVE_W-1:0] C_MAX = 16'sd16384;
    localparam logic signed [CURVE_W-1:0] C_MIN = -16'sd16384;

    logic [3:0]                 r_state;
    logic [STAGE_W-1:0]         r_stage;
    logic [LEVEL_W-1:0]         r_level;
    logic [LEVEL_W-1:0]         r_t;
    logic                       r_neg;
    logic [16:0]                r_e;
    logic [30:0]                r_z;
    logic [4:0]                 r_p;
    logic [3:0]                 r_cnt;
    logic [15:0]                r_frac;
    logic [7:0]                 r_k;
    logic [15:0]                r_f;
    logic [30:0]                r_r;
    logic [LEVEL_W-1:0]         r_pw;
    logic [LEVEL_W-1:0]         r_env;
    logic signed [SAMPLE_W-1:0] r_smp;
    logic                       r_last;
    logic [SAMPLE_W-1:0]        r_out;

    logic [STAGE_W-1:0]         n_stage;
    logic [LEVEL_W-1:0]         n_level;
    logic [LEVEL_W-1:0]         n_t;

    logic [LEVEL_W-1:0]         sus;
    logic [LEVEL_W:0]           sum_atk;
    logic [LEVEL_W:0]           thr_dec;
    logic signed [CURVE_W-1:0]  c_sat;
    logic [CURVE_W-2:0]         c_abs;
    logic [LEVEL_W-1:0]         x_in;
    logic [20:0]                mag0;
    logic [32:0]                sq;
    logic [30:0]                shifted;
    logic signed [MUL_W-1:0]    mul_a;
    logic signed [MUL_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]   prod;
    logic                       accept;

    assign accept = i_req_valid && (r_state == ST_IDLE);
    assign sus    = (i_cfg.sustain_level > ONE_LVL) ? ONE_LVL : i_cfg.sustain_level;

    // stage and level update of one tick
    always_comb begin
        sum_atk = {1'b0, r_level} + {1'b0, i_cfg.attack_step};
        thr_dec = {1'b0, sus} + {1'b0, i_cfg.decay_step};
        n_stage = r_stage;
        n_level = r_level;
        n_t     = '0;
        unique case (r_stage)
            STG_ATK: begin
                if (sum_atk >= {1'b0, ONE_LVL}) begin
                    n_level = ONE_LVL;
                    n_stage = STG_DEC;
                end else begin
                    n_level = sum_atk[LEVEL_W-1:0];
                end
                n_t = n_level;
            end
            STG_DEC: begin
                if ({1'b0, r_level} <= thr_dec) begin
                    n_level = sus;
                    n_stage = STG_SUS;
                end else begin
                    n_level = r_level - i_cfg.decay_step;
                end
                n_t = n_level;
            end
            STG_SUS: n_t = sus;
            STG_REL: begin
                if (r_level <= i_cfg.rel_step) begin
                    n_level = '0;
                    n_stage = STG_IDLE;
                end else begin
                    n_level = r_level - i_cfg.rel_step;
                end
                n_t = n_level;
            end
            default: begin
                n_stage = STG_IDLE;
                n_t     = '0;
            end
        endcase
    end

    always_comb begin
        if (i_cfg.curve_amount > C_MAX) begin
            c_sat = C_MAX;
        end else if (i_cfg.curve_amount < C_MIN) begin
            c_sat = C_MIN;
        end else begin
            c_sat = i_cfg.curve_amount;
        end
        c_abs   = c_sat[CURVE_W-1] ? (CURVE_W-1)'(-c_sat) : c_sat[CURVE_W-2:0];
        x_in    = c_sat[CURVE_W-1] ? (ONE_LVL - r_t) : r_t;
        mag0    = {5'd23 - r_p, 16'b0} - {5'b0, r_frac};
        sq      = prod[62:30];
        shifted = r_r >> (5'(r_k) + 5'd7);
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_SQ: begin
                mul_a = {1'b0, r_z};
                mul_b = {1'b0, r_z};
            end
            ST_MAG: begin
                mul_a = {11'b0, mag0};
                mul_b = {15'b0, r_e};
            end
            ST_EXP: begin
                mul_a = {1'b0, r_r};
                mul_b = {2'b0, exp_tab(r_cnt)};
            end
            ST_SMP: begin
                mul_a = MUL_W'(r_smp);
                mul_b = {8'b0, r_env};
            end
            default: ;
        endcase
    end

    adsr_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_stage <= STG_IDLE;
            r_level <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_smp  <= i_req.sample;
                        r_last <= i_req.last;
                        unique case (i_req.action)
                            ACT_ON: r_stage <= STG_ATK;
                            ACT_OFF: begin
                                if (r_stage != STG_IDLE) r_stage <= STG_REL;
                            end
                            ACT_RST: begin
                                r_stage <= STG_IDLE;
                                r_level <= '0;
                            end
                            default: begin
                                r_stage <= n_stage;
                                r_level <= n_level;
                                r_t     <= n_t;
                                r_state <= ST_PREP;
                            end
                        endcase
                    end
                end
                ST_PREP: begin
                    r_neg <= c_sat[CURVE_W-1];
                    r_e   <= 17'd16384 + {c_abs, 2'b0};
                    if (c_sat == '0) begin
                        r_env   <= r_t;
                        r_state <= ST_SMP;
                    end else if (x_in == '0) begin
                        r_pw    <= '0;
                        r_state <= ST_POST;
                    end else if (x_in[LEVEL_W-1]) begin
                        r_pw    <= ONE_LVL;
                        r_state <= ST_POST;
                    end else begin
                        r_z     <= {x_in[LEVEL_W-2:0], 8'b0};
                        r_p     <= 5'd22;
                        r_state <= ST_NORM;
                    end
                end
                ST_NORM: begin
                    if (r_z[30]) begin
                        r_cnt   <= '0;
                        r_frac  <= '0;
                        r_state <= ST_SQ;
                    end else begin
                        r_z <= {r_z[29:0], 1'b0};
                        r_p <= r_p - 5'd1;
                    end
                end
                ST_SQ: r_state <= ST_SQW;
                ST_SQW: begin
                    if (sq[31]) begin
                        r_z    <= sq[31:1];
                        r_frac <= {r_frac[14:0], 1'b1};
                    end else begin
                        r_z    <= sq[30:0];
                        r_frac <= {r_frac[14:0], 1'b0};
                    end
                    r_cnt   <= r_cnt + 4'd1;
                    r_state <= (r_cnt == 4'd15) ? ST_MAG : ST_SQ;
                end
                ST_MAG: r_state <= ST_MAGW;
                ST_MAGW: begin
                    r_k     <= prod[37:30];
                    r_f     <= prod[29:14];
                    r_r     <= 31'd1 << 30;
                    r_cnt   <= '0;
                    r_state <= ST_EXP;
                end
                ST_EXP: begin
                    if (r_f[15]) begin
                        r_state <= ST_EXPW;
                    end else begin
                        r_f     <= {r_f[14:0], 1'b0};
                        r_cnt   <= r_cnt + 4'd1;
                        if (r_cnt == 4'd15) r_state <= ST_SHF;
                    end
                end
                ST_EXPW: begin
                    r_r     <= prod[60:30];
                    r_f     <= {r_f[14:0], 1'b0};
                    r_cnt   <= r_cnt + 4'd1;
                    r_state <= (r_cnt == 4'd15) ? ST_SHF : ST_EXP;
                end
                ST_SHF: begin
                    if (r_k > 8'd23) begin
                        r_pw <= '0;
                    end else if (shifted > 31'(ONE_LVL)) begin
                        r_pw <= ONE_LVL;
                    end else begin
                        r_pw <= shifted[LEVEL_W-1:0];
                    end
                    r_state <= ST_POST;
                end
                ST_POST: begin
                    r_env   <= r_neg ? (ONE_LVL - r_pw) : r_pw;
                    r_state <= ST_SMP;
                end
                ST_SMP: r_state <= ST_SMPW;
                ST_SMPW: begin
                    r_out   <= prod[46:23];
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (i_res_take) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_idle       = (r_state == ST_IDLE);
    assign o_res_valid  = (r_state == ST_DONE);
    assign o_res.sample = r_out;
    assign o_res.env    = r_env;
    assign o_res.stage  = r_stage;
    assign o_res.last   = r_last;

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= ONE_LVL)
        else $error("level above one");

    a_stage_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stage <= STG_REL)
        else $error("stage code out of range");

    a_ctrl_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_req.action != ACT_TICK) |=> r_state == ST_IDLE)
        else $error("control request left the sequencer busy");

    a_norm_msb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SQ |-> r_z[30])
        else $error("squaring on an unnormalized value");

    a_done_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_take |=> o_res_valid)
        else $error("result dropped before hand-off");

endmodule

// ----- rtl/core/adsr_envelope_vca.sv -----
// channel   | dir | tdata (low bit up)                 | tuser       | tlast
// ----------+-----+------------------------------------+-------------+-----------
// s_axis    | in  | sample_in[23:0]                    | action[1:0] | block_last
// m_axis    | out | sample_out[23:0], envelope_out[23:0]| stage_out   | last_out
// cfg       | in  | i_cfg_we, i_cfg_addr (0..4), i_cfg_wdata[23:0]
//
// a tick holds the sequencer from accept to result: the accept cycle, a prep
// step, normalize shifts, 16 squarings, the log magnitude, the table products
// and the finishing steps, all on the one shared 32x32 multiplier; a zero curve
// or a level at 0 or 1.0 skips the normalize, squaring, log and table steps
// note on, note off and reset requests leave the sequencer idle and give no result
// i_rst_n is synchronous, active low; it restores the register defaults
// the result register lets the next request in while a result waits on m_axis
module adsr_envelope_vca (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // config write port
    input  logic                                 i_cfg_we,
    input  logic [adsr_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [adsr_pkg::LEVEL_W-1:0]         i_cfg_wdata,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [23:0]                          s_axis_tdata,  // sample_in[23:0]
    input  logic [1:0]                           s_axis_tuser,  // action[1:0]
    input  logic                                 s_axis_tlast,
    // output stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [47:0]                          m_axis_tdata,  // sample_out, envelope_out
    output logic [2:0]                           m_axis_tuser,  // stage_out[2:0]
    output logic                                 m_axis_tlast
);
    import adsr_pkg::*;

    t_cfg cfg;
    t_req req;
    t_res res;
    logic core_idle;
    logic res_valid;
    logic res_take;

    logic r_out_valid;
    t_res r_out;

    adsr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_addr  (i_cfg_addr),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    // request fields off the slave side
    assign req.action = s_axis_tuser;
    assign req.sample = s_axis_tdata;
    assign req.last   = s_axis_tlast;

    adsr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_req_valid (s_axis_tvalid),
        .i_req       (req),
        .o_idle      (core_idle),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res)
    );

    assign s_axis_tready = core_idle;

    // output register: free, or emptied in this same cycle
    assign res_take = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take && res_valid) r_out <= res;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.env, r_out.sample};
    assign m_axis_tuser  = r_out.stage;
    assign m_axis_tlast  = r_out.last;

endmodule

// ----- tb/sv/tb_adsr_envelope_vca.sv -----
`timescale 1ns / 100ps

module tb_adsr_envelope_vca;
    import adsr_pkg::*;

    localparam int        STALL_LIMIT = 5000;
    localparam int        SETTLE_CYC  = 100;
    localparam bit [63:0] UNITY       = 64'd1 << FRAC_BITS;
    localparam bit [63:0] Q30_ONE     = 64'd1 << 30;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [LEVEL_W-1:0]    i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata;   // sample_in[23:0]
    logic [1:0]            s_axis_tuser;   // action[1:0]
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [47:0]           m_axis_tdata;   // sample_out[23:0], envelope_out[47:24]
    logic [2:0]            m_axis_tuser;   // stage_out[2:0]
    logic                  m_axis_tlast;

    adsr_envelope_vca uut (.*);

    // envelope model plus queue of pending tick results
    class envelope_scoreboard;
        bit [63:0]          atk_step, dec_step, rel_step, sus_lvl;
        int                 curve;
        logic [STAGE_W-1:0] stage;
        bit [63:0]          level;
        t_res               pending[$];
        int                 errors;
        bit [63:0]          pow_tab[16];

        function new();
            pow_tab = '{64'd759250125, 64'd902905651, 64'd984625594, 64'd1028218693,
                        64'd1050733751, 64'd1062175491, 64'd1067942999, 64'd1070838486,
                        64'd1072289173, 64'd1073015252, 64'd1073378477, 64'd1073560135,
                        64'd1073650976, 64'd1073696399, 64'd1073719111, 64'd1073730468};
            errors = 0;
            clear();
        endfunction

        function void clear();
            atk_step = UNITY;
            dec_step = UNITY;
            rel_step = UNITY;
            sus_lvl  = UNITY;
            curve    = 0;
            stage    = STG_IDLE;
            level    = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [LEVEL_W-1:0] val);
            case (idx)
                REG_ATTACK:  atk_step = 64'(val);
                REG_DECAY:   dec_step = 64'(val);
                REG_RELEASE: rel_step = 64'(val);
                REG_SUSTAIN: sus_lvl  = 64'(val);
                REG_CURVE:   curve    = int'($signed(val[15:0]));
                default: ;
            endcase
        endfunction

        // x^e, x in q1.23 within [0,1], e in q.14; log2 by squaring, exp2 by table
        function bit [63:0] power(bit [63:0] x, bit [63:0] e);
            int        msb;
            int        sh;
            bit [63:0] z, frac, mag, k, f, r;
            if (x == 0) return 0;
            if (x >= UNITY) return UNITY;
            msb = 0;
            for (int i = 0; i < FRAC_BITS; i++)
                if (x[i]) msb = i;
            z = x << (30 - msb);
            frac = 0;
            for (int i = 0; i < 16; i++) begin
                z = (z * z) >> 30;
                frac = frac << 1;
                if (z >= 2 * Q30_ONE) begin
                    z = z >> 1;
                    frac = frac | 1;
                end
            end
            mag = (64'(FRAC_BITS - msb) << 16) - frac;
            mag = (mag * e) >> 14;
            k = mag >> 16;
            f = mag & 64'hFFFF;
            r = Q30_ONE;
            for (int i = 0; i < 16; i++)
                if (f[15-i]) r = (r * pow_tab[i]) >> 30;
            if (k > 64) return 0;
            sh = 30 + int'(k) - FRAC_BITS;
            if (sh >= 64) return 0;
            r = r >> sh;
            return (r > UNITY) ? UNITY : r;
        endfunction

        function bit [63:0] shaped(bit [63:0] t);
            int c;
            c = curve;
            if (c > 16384) c = 16384;
            if (c < -16384) c = -16384;
            if (t > UNITY) t = UNITY;
            if (c > 0) return power(t, 64'(16384 + 4 * c));
            if (c < 0) return UNITY - power(UNITY - t, 64'(16384 - 4 * c));
            return t;
        endfunction

        // advance the envelope for one accepted request
        function void note_request(logic [1:0] act, logic [23:0] smp, logic last);
            bit [63:0]      sus, env;
            longint         prod;
            t_res           res;
            sus = (sus_lvl > UNITY) ? UNITY : sus_lvl;
            env = 0;
            case (act)
                ACT_ON:  begin stage = STG_ATK; return; end
                ACT_OFF: begin if (stage != STG_IDLE) stage = STG_REL; return; end
                ACT_RST: begin stage = STG_IDLE; level = 0; return; end
                default: ;
            endcase
            case (stage)
                STG_ATK: begin
                    level = level + atk_step;
                    if (level >= UNITY) begin level = UNITY; stage = STG_DEC; end
                    env = shaped(level);
                end
                STG_DEC: begin
                    if (level <= sus + dec_step) begin level = sus; stage = STG_SUS; end
                    else level = level - dec_step;
                    env = shaped(level);
                end
                STG_SUS: env = shaped(sus);
                STG_REL: begin
                    if (level <= rel_step) begin level = 0; stage = STG_IDLE; end
                    else level = level - rel_step;
                    env = shaped(level);
                end
                default: begin stage = STG_IDLE; env = 0; end
            endcase
            // arithmetic shift gives the floor of the product
            prod = longint'($signed(smp)) * longint'(env);
            prod = prod >>> FRAC_BITS;
            res.sample = prod[SAMPLE_W-1:0];
            res.env    = env[LEVEL_W-1:0];
            res.stage  = stage;
            res.last   = last;
            pending.push_back(res);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %0h want %0h (t=%0t)", what, got, want, $realtime);
            errors++;
        endtask

        task check_result(logic [47:0] data, logic [2:0] stg, logic last);
            t_res want;
            if (pending.size() == 0) begin
                report("unexpected result", 64'(data), 0);
                return;
            end
            want = pending.pop_front();
            if (data[23:0] !== want.sample) report("sample_out", data[23:0], want.sample);
            if (data[47:24] !== want.env) report("envelope_out", data[47:24], want.env);
            if (stg !== want.stage) report("stage_out", stg, want.stage);
            if (last !== want.last) report("last_out", last, want.last);
        endtask
    endclass

    envelope_scoreboard sb;
    int burst_left;
    int sent_count;
    int quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver stall pattern: the mode is picked anew at random as the phase counter runs
    int rx_mode;
    int rx_phase;
    initial rx_mode = 0;
    initial rx_phase = 0;
    initial m_axis_tready = 1'b0;
    always @(posedge i_clk) begin
        rx_phase <= rx_phase + 1;
        if (rx_phase % 64 == 63) rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 1) == 1);
            2: m_axis_tready <= ($urandom_range(0, 7) == 0);
            default: m_axis_tready <= (rx_phase % 16) < 5;
        endcase
    end

    // result check; values sampled are those from before the edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    // watchdog on cycles with no request, no result and no register write
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // one request; the sender runs in bursts with random gaps between them
    task send(logic [1:0] act, logic [23:0] smp, logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= smp;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(act, smp, last);
        burst_left--;
        sent_count++;
    endtask

    task send_tick();
        send(ACT_TICK, 24'($urandom), 1'($urandom));
    endtask

    // drain all results, then allow for a request still in flight
    task drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // write enable stays high across a series of writes
    task write_reg(logic [CFG_ADDR_W-1:0] idx, logic [LEVEL_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task write_all(logic [23:0] atk, logic [23:0] dec, logic [23:0] rel,
                   logic [23:0] sus, logic [23:0] crv);
        write_reg(REG_ATTACK, atk);
        write_reg(REG_DECAY, dec);
        write_reg(REG_RELEASE, rel);
        write_reg(REG_SUSTAIN, sus);
        write_reg(REG_CURVE, crv);
        i_cfg_we <= 1'b0;
    endtask

    function logic [23:0] rand_step();
        return ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(1 << 14, 1 << 21));
    endfunction

    // mostly complete notes with random content, plus some noise
    task random_notes(int target);
        int n;
        while (sent_count < target) begin
            if ($urandom_range(0, 9) < 8) begin
                send(ACT_ON, 24'($urandom), 1'($urandom));
                n = $urandom_range(2, 60);
                repeat (n) send_tick();
                if ($urandom_range(0, 5) == 0) begin
                    // retrigger mid-note
                    send(ACT_ON, 24'($urandom), 1'($urandom));
                    repeat ($urandom_range(1, 20)) send_tick();
                end
                send(ACT_OFF, 24'($urandom), 1'($urandom));
                n = $urandom_range(1, 60);
                repeat (n) send_tick();
            end else begin
                repeat ($urandom_range(1, 6)) send(2'($urandom), 24'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        sb = new();
        burst_left   = 0;
        sent_count   = 0;
        quiet_cycles = 0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ACT_TICK;
        s_axis_tlast  <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset defaults, every action, stage walk, sample extremes
        send(ACT_TICK, 24'h7FFFFF, 1'b1);          // tick while idle
        send(ACT_OFF, 24'h0, 1'b0);                // note off while idle stays idle
        send(ACT_TICK, 24'h800000, 1'b0);
        send(ACT_ON, 24'h0, 1'b0);
        send(ACT_TICK, 24'h7FFFFF, 1'b0);          // full step: attack to decay
        send(ACT_TICK, 24'h800000, 1'b1);          // decay to sustain
        send(ACT_TICK, 24'h800000, 1'b0);          // sustain hold
        send(ACT_TICK, 24'h000000, 1'b1);
        send(ACT_OFF, 24'hFFFFFF, 1'b1);
        send(ACT_TICK, 24'hFFFFFF, 1'b0);          // release to zero
        send(ACT_ON, 24'h0, 1'b0);
        send(ACT_RST, 24'h0, 1'b0);                // reset action back to idle
        send(ACT_TICK, 24'h000001, 1'b0);
        drain();

        // minimum steps, no sustain, strongest convex curve
        write_all(24'd1, 24'd1, 24'd1, 24'd0, 24'd16384);
        send(ACT_ON, 24'h0, 1'b0);
        repeat (4) send(ACT_TICK, 24'h800000, 1'b0);
        send(ACT_TICK, 24'h7FFFFF, 1'b1);
        send(ACT_RST, 24'h0, 1'b0);
        random_notes(160);
        drain();

        // sustain above one, strongest concave curve
        write_all(rand_step(), rand_step(), rand_step(), 24'hFFFFFF, 24'(-16384));
        random_notes(320);
        drain();

        // curve below range saturates, random sustain
        write_all(rand_step(), rand_step(), rand_step(), 24'($urandom_range(0, 1 << 23)),
                  24'h008000);
        random_notes(480);
        drain();

        // curve above range, zero and oversized steps
        write_all(24'hFFFFFF, 24'd0, rand_step(), 24'($urandom_range(0, 1 << 23)), 24'h007FFF);
        random_notes(560);
        drain();
        write_all(rand_step(), 24'hFFFFFF, 24'd0, 24'($urandom), 24'h00FFFF);
        random_notes(640);
        drain();

        // fully random settings
        while (sent_count < 950) begin
            write_all(rand_step(), rand_step(), rand_step(), 24'($urandom_range(0, 1 << 23)),
                      24'($urandom_range(0, 32768)) - 24'd16384);
            random_notes((sent_count + 100 < 950) ? sent_count + 100 : 950);
            drain();
        end

        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/adsr_pkg.sv
rtl/core/adsr_mul.sv
rtl/core/adsr_cfg.sv
rtl/core/adsr_core.sv
rtl/core/adsr_envelope_vca.sv
tb/sv/tb_adsr_envelope_vca.sv
